FILE: rtl/prc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prc_pkg
// Types, register codes and constants shared by the pulse rate classifier.
// ----------------------------------------------------------------------------
package prc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_TOTAL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_A    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_B    = 3'd4;

    localparam logic [9:0]  RST_DEBOUNCE  = 10'd40;
    localparam logic [19:0] RST_WINDOW    = 20'd200000;
    localparam logic [4:0]  RST_WIN_TOTAL = 5'd5;
    localparam logic [15:0] RST_RATE_A    = 16'd547;
    localparam logic [15:0] RST_RATE_B    = 16'd312;

    localparam logic [10:0] SINCE_MAX = 11'd2047;
    localparam logic [15:0] COUNT_MAX = 16'd65535;
    localparam logic [22:0] AVG_MAX   = 23'h7FFFFF;
    localparam logic [9:0]  CONF_MAX  = 10'd1000;
    localparam logic [9:0]  CONF_LOW  = 10'd400;
    localparam logic [4:0]  SET_MAX   = 5'd16;

    // divider quotient lengths: average rate and confidence
    localparam int Q_LONG  = 23;
    localparam int Q_SHORT = 10;

    localparam int D_W   = 24;   // window length times set size
    localparam int XR_W  = 40;   // class rate times D
    localparam int NC_W  = 50;   // confidence numerator, below 1000 * 2^40

    typedef struct packed {
        logic [9:0]  debounce_ticks;
        logic [19:0] window_ticks;
        logic [4:0]  window_total;
        logic [15:0] rate_a_hz;
        logic [15:0] rate_b_hz;
    } t_cfg;

    // one finished window, front to back
    typedef struct packed {
        logic [15:0] pulses;
        logic [3:0]  number;
        logic        set_done;
        logic [19:0] total;
    } t_rec;

    typedef struct packed {
        logic [15:0] window_pulses;
        logic [3:0]  window_number;
        logic        set_done;
        logic [22:0] avg_rate_centihz;
        logic        class_is_a;
        logic [9:0]  confidence_tenths;
        logic        low_confidence;
    } t_res;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_MUL1,
        BK_MUL2,
        BK_DIFF,
        BK_CMP,
        BK_DIVA,
        BK_MULC,
        BK_STC,
        BK_DIVC,
        BK_DONE
    } t_bk_state;

    // windows per set, with zero read as one and anything above sixteen as sixteen
    function automatic logic [4:0] set_size(input logic [4:0] total);
        logic [4:0] n;
        n = total;
        if (total == 5'd0) begin
            n = 5'd1;
        end else if (total > SET_MAX) begin
            n = SET_MAX;
        end
        return n;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/prc_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prc_fifo
// Small flop-based queue between the window counter and the calculator.
// ----------------------------------------------------------------------------
module prc_fifo #(
    parameter int WIDTH = 41,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_rdata,
    output logic                  o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [AW:0]      r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/prc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prc_front
// Debounces edges, counts pulses per window and emits one record per window.
// ----------------------------------------------------------------------------
module prc_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_tick,
    input  wire logic          i_edge,
    input  wire prc_pkg::t_cfg i_cfg,
    output logic               o_push,
    output prc_pkg::t_rec      o_rec
);

    logic [10:0] r_since, n_since;
    logic [19:0] r_wtc, n_wtc;
    logic [15:0] r_cnt, n_cnt;
    logic [3:0]  r_idx, n_idx;
    logic [19:0] r_total, n_total;

    logic [10:0] since_inc;
    logic        accept_edge;
    logic [15:0] cnt_inc;
    logic [19:0] wtc_inc;
    logic        win_end;
    logic [19:0] total_sum;
    logic        last;

    always_comb begin
        since_inc   = (r_since < prc_pkg::SINCE_MAX) ? r_since + 11'd1 : r_since;
        accept_edge = i_edge && (since_inc > {1'b0, i_cfg.debounce_ticks});
        cnt_inc     = (accept_edge && r_cnt < prc_pkg::COUNT_MAX) ? r_cnt + 16'd1 : r_cnt;
        wtc_inc     = r_wtc + 20'd1;
        win_end     = (wtc_inc >= i_cfg.window_ticks);
        total_sum   = r_total + {4'd0, cnt_inc};
        last        = ({1'b0, r_idx} + 5'd1) >= prc_pkg::set_size(i_cfg.window_total);

        n_since = accept_edge ? 11'd0 : since_inc;
        n_cnt   = cnt_inc;
        n_wtc   = wtc_inc;
        n_idx   = r_idx;
        n_total = r_total;
        if (win_end) begin
            n_wtc   = '0;
            n_cnt   = '0;
            n_idx   = last ? 4'd0 : r_idx + 4'd1;
            n_total = last ? 20'd0 : total_sum;
        end

        o_push          = i_tick && win_end;
        o_rec.pulses    = cnt_inc;
        o_rec.number    = r_idx;
        o_rec.set_done  = last;
        o_rec.total     = total_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_since <= '0;
            r_wtc   <= '0;
            r_cnt   <= '0;
            r_idx   <= '0;
            r_total <= '0;
        end else if (i_tick) begin
            r_since <= n_since;
            r_wtc   <= n_wtc;
            r_cnt   <= n_cnt;
            r_idx   <= n_idx;
            r_total <= n_total;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/prc_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prc_div
// Restoring divider, one quotient bit per cycle, 23 or 10 quotient bits.
// The caller guarantees the quotient fits, so the remainder starts as the
// numerator shifted right by the quotient length.
// ----------------------------------------------------------------------------
module prc_div #(
    parameter int NUM_W = 54
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic                     i_long,
    input  wire logic [NUM_W-1:0]         i_num,
    input  wire logic [prc_pkg::XR_W-1:0] i_den,
    output logic                          o_busy,
    output logic [prc_pkg::Q_LONG-1:0]    o_quo
);

    localparam int RW = prc_pkg::XR_W;
    localparam int QL = prc_pkg::Q_LONG;
    localparam int QS = prc_pkg::Q_SHORT;

    logic [RW-1:0] r_rem;
    logic [RW-1:0] r_den;
    logic [QL-1:0] r_low;
    logic [QL-1:0] r_quo;
    logic [4:0]    r_cnt;
    logic          r_busy;

    logic [RW:0]   trial;
    logic          fits;

    // divisor is captured at start; the caller's mux may move on afterwards
    assign trial  = {r_rem, r_low[QL-1]};
    assign fits   = (trial >= {1'b0, r_den});
    assign o_busy = r_busy;
    assign o_quo  = r_quo;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= '0;
            r_den <= i_den;
            if (i_long) begin
                r_rem <= RW'(i_num >> QL);
                r_low <= i_num[QL-1:0];
            end else begin
                r_rem <= RW'(i_num >> QS);
                r_low <= {i_num[QS-1:0], {(QL-QS){1'b0}}};
            end
        end else if (r_busy) begin
            r_rem <= fits ? RW'(trial - {1'b0, r_den}) : RW'(trial);
            r_low <= {r_low[QL-2:0], 1'b0};
            r_quo <= {r_quo[QL-2:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_long ? 5'(QL) : 5'(QS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 5'd1;
            if (r_cnt == 5'd1) begin
                r_busy <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/prc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prc_back
// Takes window records from the queue, computes the set average, class and
// confidence on set-ending windows, and holds the result for the consumer.
// ----------------------------------------------------------------------------
module prc_back #(
    parameter int TICKS_PER_SECOND = 1000000
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire prc_pkg::t_cfg i_cfg,
    input  wire logic          i_q_empty,
    input  wire prc_pkg::t_rec i_q_rec,
    output logic               o_q_pop,
    input  wire logic          i_pop,
    output logic               o_empty,
    output prc_pkg::t_res      o_res
);

    localparam int TPS_W  = $clog2(TICKS_PER_SECOND + 1);
    localparam int X_W    = 20 + TPS_W;
    localparam int X100_W = X_W + 7;
    localparam int CW     = (X_W + 1 > prc_pkg::XR_W + 1) ? X_W + 1 : prc_pkg::XR_W + 1;
    localparam int SW     = (X100_W > prc_pkg::D_W + prc_pkg::Q_LONG) ?
                            X100_W : prc_pkg::D_W + prc_pkg::Q_LONG;
    localparam int NUM_W  = (X100_W > prc_pkg::NC_W) ? X100_W : prc_pkg::NC_W;
    localparam int XR_W   = prc_pkg::XR_W;
    localparam int D_W    = prc_pkg::D_W;

    prc_pkg::t_bk_state r_state, n_state;

    prc_pkg::t_rec      r_rec;
    prc_pkg::t_res      r_res, res_next;
    logic               r_res_vld;

    logic [D_W-1:0]         r_d;
    logic [X_W-1:0]         r_x;
    logic [X100_W-1:0]      r_x100;
    logic [XR_W-1:0]        r_xa, r_xb, r_sep;
    logic [CW-1:0]          r_da, r_db, r_mid;
    logic                   r_cls, r_conf_sat, r_avg_sat;
    logic [prc_pkg::NC_W-1:0] r_numc;
    logic [22:0]            r_avg;
    logic [9:0]             r_conf;

    logic                   out_free;
    logic                   load_out;
    logic                   div_start, div_long, div_busy;
    logic [NUM_W-1:0]       div_num;
    logic [XR_W-1:0]        div_den;
    logic [prc_pkg::Q_LONG-1:0] div_quo;

    logic [19:0]            wlen;
    logic [CW-1:0]          xe, ae, be, x2, ab_sum;
    logic [XR_W-1:0]        mid40;
    logic [9:0]             conf_fin;

    assign out_free = !r_res_vld || i_pop;
    assign o_empty  = !r_res_vld;
    assign o_res    = r_res;
    assign wlen     = (i_cfg.window_ticks == 20'd0) ? 20'd1 : i_cfg.window_ticks;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            prc_pkg::BK_IDLE: begin
                if (!i_q_empty && i_q_rec.set_done) begin
                    n_state = prc_pkg::BK_MUL1;
                end
            end
            prc_pkg::BK_MUL1: n_state = prc_pkg::BK_MUL2;
            prc_pkg::BK_MUL2: n_state = prc_pkg::BK_DIFF;
            prc_pkg::BK_DIFF: n_state = prc_pkg::BK_CMP;
            prc_pkg::BK_CMP:  n_state = prc_pkg::BK_DIVA;
            prc_pkg::BK_DIVA: begin
                if (!div_busy) begin
                    n_state = prc_pkg::BK_MULC;
                end
            end
            prc_pkg::BK_MULC: n_state = prc_pkg::BK_STC;
            prc_pkg::BK_STC:  n_state = prc_pkg::BK_DIVC;
            prc_pkg::BK_DIVC: begin
                if (!div_busy) begin
                    n_state = prc_pkg::BK_DONE;
                end
            end
            prc_pkg::BK_DONE: begin
                if (out_free) begin
                    n_state = prc_pkg::BK_IDLE;
                end
            end
            default: n_state = prc_pkg::BK_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_q_pop   = 1'b0;
        load_out  = 1'b0;
        div_start = 1'b0;
        div_long  = 1'b0;
        unique case (r_state)
            prc_pkg::BK_IDLE: begin
                o_q_pop  = !i_q_empty && (i_q_rec.set_done || out_free);
                load_out = !i_q_empty && !i_q_rec.set_done && out_free;
            end
            prc_pkg::BK_CMP: begin
                div_start = 1'b1;
                div_long  = 1'b1;
            end
            prc_pkg::BK_STC: div_start = 1'b1;
            prc_pkg::BK_DONE: load_out = out_free;
            default: ;
        endcase
    end

    assign div_num = div_long ? NUM_W'(r_x100) : NUM_W'(r_numc);
    assign div_den = div_long ? XR_W'(r_d) : r_sep;

    prc_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_long  (div_long),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quo   (div_quo)
    );

    // distances, all scaled by D so no fractions appear
    always_comb begin
        xe     = CW'(r_x);
        ae     = CW'(r_xa);
        be     = CW'(r_xb);
        x2     = xe << 1;
        ab_sum = ae + be;
        mid40  = r_mid[XR_W-1:0];
        conf_fin = r_conf_sat ? prc_pkg::CONF_MAX : r_conf;
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            prc_pkg::BK_IDLE: r_rec <= i_q_rec;
            prc_pkg::BK_MUL1: begin
                r_d <= D_W'(wlen) * D_W'(prc_pkg::set_size(i_cfg.window_total));
                r_x <= X_W'(r_rec.total) * X_W'(TICKS_PER_SECOND);
            end
            prc_pkg::BK_MUL2: begin
                r_xa   <= XR_W'(i_cfg.rate_a_hz) * XR_W'(r_d);
                r_xb   <= XR_W'(i_cfg.rate_b_hz) * XR_W'(r_d);
                // times 100 = 64 + 32 + 4
                r_x100 <= (X100_W'(r_x) << 6) + (X100_W'(r_x) << 5) + (X100_W'(r_x) << 2);
            end
            prc_pkg::BK_DIFF: begin
                r_da  <= (xe >= ae) ? xe - ae : ae - xe;
                r_db  <= (xe >= be) ? xe - be : be - xe;
                r_mid <= (x2 >= ab_sum) ? x2 - ab_sum : ab_sum - x2;
                r_sep <= (r_xa >= r_xb) ? r_xa - r_xb : r_xb - r_xa;
            end
            prc_pkg::BK_CMP: begin
                r_cls      <= (r_da <= r_db);
                r_conf_sat <= (r_sep == '0) || (r_mid >= CW'(r_sep));
                r_avg_sat  <= SW'(r_x100) >= (SW'(r_d) << prc_pkg::Q_LONG);
            end
            prc_pkg::BK_DIVA: r_avg <= div_quo;
            prc_pkg::BK_MULC: begin
                // times 1000 = 1024 - 16 - 8
                r_numc <= (prc_pkg::NC_W'(mid40) << 10) - (prc_pkg::NC_W'(mid40) << 4)
                          - (prc_pkg::NC_W'(mid40) << 3);
            end
            prc_pkg::BK_DIVC: r_conf <= div_quo[prc_pkg::Q_SHORT-1:0];
            default: ;
        endcase
    end

    always_comb begin
        res_next = '0;
        if (r_state == prc_pkg::BK_DONE) begin
            res_next.window_pulses     = r_rec.pulses;
            res_next.window_number     = r_rec.number;
            res_next.set_done          = 1'b1;
            res_next.avg_rate_centihz  = r_avg_sat ? prc_pkg::AVG_MAX : r_avg;
            res_next.class_is_a        = r_cls;
            res_next.confidence_tenths = conf_fin;
            res_next.low_confidence    = (conf_fin < prc_pkg::CONF_LOW);
        end else begin
            res_next.window_pulses     = i_q_rec.pulses;
            res_next.window_number     = i_q_rec.number;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_res <= res_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= prc_pkg::BK_IDLE;
            r_res_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_res_vld <= 1'b1;
            end else if (i_pop) begin
                r_res_vld <= 1'b0;
            end
        end
    end

    ap_conf_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_vld |-> r_res.confidence_tenths <= prc_pkg::CONF_MAX)
        else $error("confidence above cap");

    ap_partial_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_vld && !r_res.set_done |->
            r_res.avg_rate_centihz == '0 && !r_res.class_is_a &&
            r_res.confidence_tenths == '0 && !r_res.low_confidence)
        else $error("final fields set on a partial window");

    ap_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    ap_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_vld && !i_pop |=> r_res_vld && $stable(r_res))
        else $error("waiting result changed before pop");

endmodule
`default_nettype wire

FILE: rtl/pulse_rate_classifier.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pulse_rate_classifier
// Debounced pulse counter over fixed windows with a two-rate classifier.
// ----------------------------------------------------------------------------
// Input channel: one transaction per microsecond tick (push/full), carrying
// the falling-edge flag. Result channel (empty/pop): one transaction at the
// end of each counting window; ticks that do not end a window give nothing.
// Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_wdata) take effect at the
// next edge; indexes beyond the register list are ignored.
// A window that does not close a set passes through the queue and then the
// result register, once the calculator is idle and the result register is
// free. The window that closes a set goes through the calculator: six steps,
// a 23-bit average division and a 10-bit confidence division; its result is
// loaded when the result register is free. Both divisions share a single
// divider. Records wait in a four-entry queue meanwhile, so ticks keep
// flowing while the calculator is busy or the consumer stalls; full rises
// only when that queue fills.
// Reset restores the default registers, clears all counters, empties the queue
// and marks the result register empty.
// ----------------------------------------------------------------------------
module pulse_rate_classifier #(
    parameter int TICKS_PER_SECOND = 1000000
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              push,
    output logic                                   full,
    input  wire logic                              i_falling_edge,
    input  wire logic                              pop,
    output logic                                   empty,
    output logic [15:0]                            o_window_pulses,
    output logic [3:0]                             o_window_number,
    output logic                                   o_set_done,
    output logic [22:0]                            o_avg_rate_centihz,
    output logic                                   o_class_is_a,
    output logic [9:0]                             o_confidence_tenths,
    output logic                                   o_low_confidence,
    input  wire logic                              i_cfg_we,
    input  wire logic [prc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [prc_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    localparam int REC_W = $bits(prc_pkg::t_rec);

    prc_pkg::t_cfg r_cfg;
    prc_pkg::t_rec front_rec, q_rec;
    prc_pkg::t_res res;
    logic          tick, front_push, q_full, q_empty, q_pop;
    logic [REC_W-1:0] q_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks <= prc_pkg::RST_DEBOUNCE;
            r_cfg.window_ticks   <= prc_pkg::RST_WINDOW;
            r_cfg.window_total   <= prc_pkg::RST_WIN_TOTAL;
            r_cfg.rate_a_hz      <= prc_pkg::RST_RATE_A;
            r_cfg.rate_b_hz      <= prc_pkg::RST_RATE_B;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                prc_pkg::REG_DEBOUNCE:  r_cfg.debounce_ticks <= i_cfg_wdata[9:0];
                prc_pkg::REG_WINDOW:    r_cfg.window_ticks   <= i_cfg_wdata;
                prc_pkg::REG_WIN_TOTAL: r_cfg.window_total   <= i_cfg_wdata[4:0];
                prc_pkg::REG_RATE_A:    r_cfg.rate_a_hz      <= i_cfg_wdata[15:0];
                prc_pkg::REG_RATE_B:    r_cfg.rate_b_hz      <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    assign full = q_full;
    assign tick = push && !q_full;

    prc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tick  (tick),
        .i_edge  (i_falling_edge),
        .i_cfg   (r_cfg),
        .o_push  (front_push),
        .o_rec   (front_rec)
    );

    prc_fifo #(
        .WIDTH (REC_W),
        .DEPTH (4)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_wdata (front_rec),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_rdata (q_rdata),
        .o_empty (q_empty)
    );

    assign q_rec = prc_pkg::t_rec'(q_rdata);

    prc_back #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_empty (q_empty),
        .i_q_rec   (q_rec),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_res     (res)
    );

    assign o_window_pulses     = res.window_pulses;
    assign o_window_number     = res.window_number;
    assign o_set_done          = res.set_done;
    assign o_avg_rate_centihz  = res.avg_rate_centihz;
    assign o_class_is_a        = res.class_is_a;
    assign o_confidence_tenths = res.confidence_tenths;
    assign o_low_confidence    = res.low_confidence;

endmodule
`default_nettype wire
